[rtl/core/tpl_pkg.sv]
// ----------------------------------------------------------------------------
// tpl_pkg
// Shared types and constants of the tank pump level controller.
// ----------------------------------------------------------------------------
package tpl_pkg;

    // bits of the sensor reading that are used
    localparam int READING_BITS = 10;

    localparam int PCT_W      = 7;
    localparam int CM_W       = 10;
    localparam int LEVEL_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam int PCT_SCALE  = 100;
    localparam int SUM_W      = CM_W + 1;
    localparam int DIFF_W     = ((READING_BITS > SUM_W) ? READING_BITS : SUM_W) + 1;
    localparam int PROD_W     = DIFF_W + 7;
    localparam int MAG_W      =
        $clog2(((READING_BITS > SUM_W) ? (1 << READING_BITS) : (1 << SUM_W)) * PCT_SCALE);
    localparam int DIV_CNT_W  = $clog2(MAG_W + 1);

    localparam logic signed [PROD_W-1:0]  PCT_SCALE_S = PROD_W'(PCT_SCALE);
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN   = LEVEL_W'(-512);
    localparam logic signed [LEVEL_W-1:0] LEVEL_MAX   = LEVEL_W'(511);

    localparam logic [PCT_W-1:0] STOP_FILL_RESET  = PCT_W'(80);
    localparam logic [PCT_W-1:0] REFILL_RESET     = PCT_W'(20);
    localparam logic [CM_W-1:0]  SENSOR_HT_RESET  = CM_W'(20);
    localparam logic [CM_W-1:0]  WATER_DEPTH_RESET = CM_W'(200);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STOP_FILL     = 2'd0,
        CFG_REFILL        = 2'd1,
        CFG_SENSOR_HEIGHT = 2'd2,
        CFG_WATER_DEPTH   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_READING = 2'd1,
        OP_COMMIT  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        MODE_OFF       = 2'd0,
        MODE_AUTO      = 2'd1,
        MODE_FILL_AUTO = 2'd2,
        MODE_FILL_OFF  = 2'd3
    } mode_t;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;

endpackage

[rtl/core/tpl_if.sv]
// ----------------------------------------------------------------------------
// tpl_if
// Request and result channels of the tank pump level controller.
// ----------------------------------------------------------------------------
interface tpl_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        opcode;
    logic [tpl_pkg::READING_BITS-1:0]  sensor_distance_cm;
    logic [1:0]                        new_mode;

    modport source (output valid, output opcode, output sensor_distance_cm,
                    output new_mode, input ready);
    modport sink   (input valid, input opcode, input sensor_distance_cm,
                    input new_mode, output ready);
endinterface

interface tpl_out_if;
    logic                                valid;
    logic                                ready;
    logic                                pump_on;
    logic [1:0]                          mode_now;
    logic signed [tpl_pkg::LEVEL_W-1:0]  level_percent;
    logic                                level_moved;

    modport source (output valid, output pump_on, output mode_now,
                    output level_percent, output level_moved, input ready);
    modport sink   (input valid, input pump_on, input mode_now,
                    input level_percent, input level_moved, output ready);
endinterface

[rtl/core/tpl_div.sv]
// ----------------------------------------------------------------------------
// tpl_div
// Restoring divider, one quotient bit per cycle through a subtractor.
// ----------------------------------------------------------------------------
module tpl_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tpl_pkg::div_ctl_t           ctl_in,
    output tpl_pkg::div_ctl_t           ctl_out,
    input  logic [tpl_pkg::MAG_W-1:0]   dividend,
    input  logic [tpl_pkg::CM_W-1:0]    divisor,
    output logic [tpl_pkg::MAG_W-1:0]   quotient
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [tpl_pkg::CM_W-1:0]        rem_reg, rem_next;
    logic [tpl_pkg::MAG_W-1:0]       quo_reg, quo_next;
    logic [tpl_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;

    logic [tpl_pkg::CM_W:0]          shifted;
    logic [tpl_pkg::CM_W:0]          diff;
    logic                            fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[tpl_pkg::MAG_W-1]};
        diff    = shifted - {1'b0, divisor};
        fits    = (shifted >= {1'b0, divisor});

        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;

        if (ctl_in.start)
        begin
            busy_next = 1'b1;
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits in CM_W bits
            rem_next = fits ? diff[tpl_pkg::CM_W-1:0] : shifted[tpl_pkg::CM_W-1:0];
            quo_next = {quo_reg[tpl_pkg::MAG_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == tpl_pkg::DIV_CNT_W'(tpl_pkg::MAG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient      = quo_reg;
    assign ctl_out.start = 1'b0;
    assign ctl_out.done  = done_reg;

endmodule

[rtl/core/tank_pump_level_controller.sv]
// ----------------------------------------------------------------------------
// tank_pump_level_controller
// Pump mode sequencer and level tracker with an iterative level divider.
// ----------------------------------------------------------------------------
// flow: a tick or commit goes from ST_IDLE to ST_WRITE and then to the output
// register; a reading with a nonzero water depth passes through ST_MUL and ST_DIV
// first, where the one-bit-per-cycle divider divides by the water depth
// one request at a time; ST_WRITE holds while the output is stalled, and
// a finished result may wait while the next is taken
// reset: level 0, pump off, mode off, registers at their default values
module tank_pump_level_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    tpl_in_if.sink                            item,
    tpl_out_if.source                         result,
    input  logic                              cfg_wr_en,
    input  logic [tpl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tpl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_WRITE
    } state_t;

    state_t                               state_reg;
    logic [tpl_pkg::PCT_W-1:0]            stop_reg;
    logic [tpl_pkg::PCT_W-1:0]            refill_reg;
    logic [tpl_pkg::CM_W-1:0]             height_reg;
    logic [tpl_pkg::CM_W-1:0]             depth_reg;
    logic signed [tpl_pkg::LEVEL_W-1:0]   level_reg;
    logic                                 pump_reg;
    tpl_pkg::mode_t                       mode_reg;
    logic                                 moved_reg;
    logic signed [tpl_pkg::DIFF_W-1:0]    diff_reg;

    logic                                 out_valid_reg;
    logic                                 out_pump_reg;
    logic [1:0]                           out_mode_reg;
    logic signed [tpl_pkg::LEVEL_W-1:0]   out_level_reg;
    logic                                 out_moved_reg;

    tpl_pkg::div_ctl_t                    div_in;
    tpl_pkg::div_ctl_t                    div_out;
    logic [tpl_pkg::MAG_W-1:0]            quotient;

    logic                                 accept;
    logic signed [tpl_pkg::LEVEL_W:0]     lvl_x;
    logic                                 at_stop;
    logic                                 at_refill;
    logic                                 rule_pump;
    tpl_pkg::mode_t                       rule_mode;
    logic                                 commit_pump;
    tpl_pkg::mode_t                       commit_mode;
    logic [tpl_pkg::SUM_W-1:0]            sum;
    logic signed [tpl_pkg::DIFF_W-1:0]    diff_now;
    logic signed [tpl_pkg::PROD_W-1:0]    prod;
    logic [tpl_pkg::PROD_W-1:0]           prod_abs;
    logic signed [tpl_pkg::LEVEL_W-1:0]   target;
    logic                                 out_free;

    assign accept     = item.valid && item.ready;
    assign item.ready = (state_reg == ST_IDLE);
    assign out_free   = !out_valid_reg || result.ready;

    // mode rule on the level held at the start of the request
    always_comb
    begin
        lvl_x     = {level_reg[tpl_pkg::LEVEL_W-1], level_reg};
        at_stop   = (lvl_x >= $signed({4'b0, stop_reg}));
        at_refill = (lvl_x <= $signed({4'b0, refill_reg}));
        rule_pump = pump_reg;
        rule_mode = mode_reg;
        unique case (mode_reg)
            tpl_pkg::MODE_AUTO:
            begin
                if (at_stop && pump_reg)
                    rule_pump = 1'b0;
                else if (at_refill && !pump_reg)
                    rule_pump = 1'b1;
            end
            tpl_pkg::MODE_FILL_AUTO, tpl_pkg::MODE_FILL_OFF:
            begin
                if (at_stop && pump_reg)
                begin
                    rule_pump = 1'b0;
                    rule_mode = (mode_reg == tpl_pkg::MODE_FILL_AUTO) ?
                                tpl_pkg::MODE_AUTO : tpl_pkg::MODE_OFF;
                end
            end
            default:
            begin
                rule_pump = pump_reg;
            end
        endcase

        commit_mode = tpl_pkg::mode_t'(item.new_mode);
        commit_pump = rule_pump;
        unique case (commit_mode)
            tpl_pkg::MODE_OFF:  commit_pump = 1'b0;
            tpl_pkg::MODE_AUTO: commit_pump = at_refill ? 1'b1 : rule_pump;
            default:            commit_pump = !at_stop ? 1'b1 : rule_pump;
        endcase
    end

    // distance below full surface, scaled to percent
    always_comb
    begin
        sum      = {1'b0, depth_reg} + {1'b0, height_reg};
        diff_now = $signed(tpl_pkg::DIFF_W'(sum) -
                           tpl_pkg::DIFF_W'(item.sensor_distance_cm));
        prod     = tpl_pkg::PROD_W'(diff_reg) * tpl_pkg::PCT_SCALE_S;
        prod_abs = prod[tpl_pkg::PROD_W-1] ? tpl_pkg::PROD_W'(-prod) : prod;
    end

    assign div_in.start = (state_reg == ST_MUL);
    assign div_in.done  = 1'b0;

    tpl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (div_in),
        .ctl_out  (div_out),
        .dividend (prod_abs[tpl_pkg::MAG_W-1:0]),
        .divisor  (depth_reg),
        .quotient (quotient)
    );

    // saturate the truncated quotient to the level range
    always_comb
    begin
        if (diff_reg[tpl_pkg::DIFF_W-1])
        begin
            if (quotient > tpl_pkg::MAG_W'(512))
                target = tpl_pkg::LEVEL_MIN;
            else
                target = -$signed(quotient[tpl_pkg::LEVEL_W-1:0]);
        end
        else
        begin
            if (quotient > tpl_pkg::MAG_W'(511))
                target = tpl_pkg::LEVEL_MAX;
            else
                target = $signed(quotient[tpl_pkg::LEVEL_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stop_reg      <= tpl_pkg::STOP_FILL_RESET;
            refill_reg    <= tpl_pkg::REFILL_RESET;
            height_reg    <= tpl_pkg::SENSOR_HT_RESET;
            depth_reg     <= tpl_pkg::WATER_DEPTH_RESET;
            level_reg     <= '0;
            pump_reg      <= 1'b0;
            mode_reg      <= tpl_pkg::MODE_OFF;
            moved_reg     <= 1'b0;
            diff_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (tpl_pkg::cfg_idx_t'(cfg_index))
                    tpl_pkg::CFG_STOP_FILL:     stop_reg   <= cfg_data[tpl_pkg::PCT_W-1:0];
                    tpl_pkg::CFG_REFILL:        refill_reg <= cfg_data[tpl_pkg::PCT_W-1:0];
                    tpl_pkg::CFG_SENSOR_HEIGHT: height_reg <= cfg_data[tpl_pkg::CM_W-1:0];
                    tpl_pkg::CFG_WATER_DEPTH:   depth_reg  <= cfg_data[tpl_pkg::CM_W-1:0];
                    default:                    depth_reg  <= depth_reg;
                endcase
            end

            if (state_reg == ST_WRITE && out_free)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        moved_reg <= 1'b0;
                        diff_reg  <= diff_now;
                        case (item.opcode)
                            tpl_pkg::OP_READING:
                            begin
                                pump_reg <= rule_pump;
                                mode_reg <= rule_mode;
                                // zero depth leaves the level alone
                                if (depth_reg != '0)
                                    state_reg <= ST_MUL;
                                else
                                    state_reg <= ST_WRITE;
                            end
                            tpl_pkg::OP_COMMIT:
                            begin
                                pump_reg  <= commit_pump;
                                mode_reg  <= commit_mode;
                                state_reg <= ST_WRITE;
                            end
                            default:
                            begin
                                pump_reg  <= rule_pump;
                                mode_reg  <= rule_mode;
                                state_reg <= ST_WRITE;
                            end
                        endcase
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_out.done)
                    begin
                        state_reg <= ST_WRITE;
                        if (target > level_reg)
                        begin
                            level_reg <= level_reg + 1'b1;
                            moved_reg <= 1'b1;
                        end
                        else if (target < level_reg)
                        begin
                            level_reg <= level_reg - 1'b1;
                            moved_reg <= 1'b1;
                        end
                    end
                end
                ST_WRITE:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE && out_free)
        begin
            out_pump_reg  <= pump_reg;
            out_mode_reg  <= mode_reg;
            out_level_reg <= level_reg;
            out_moved_reg <= moved_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.pump_on       = out_pump_reg;
    assign result.mode_now      = out_mode_reg;
    assign result.level_percent = out_level_reg;
    assign result.level_moved   = out_moved_reg;

endmodule

[rtl/core/tpl_checker.sv]
// ----------------------------------------------------------------------------
// tpl_checker
// Port-level checks of the tank pump level controller.
// ----------------------------------------------------------------------------
module tpl_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic                              pump_on,
    input logic [1:0]                        mode_now,
    input logic signed [tpl_pkg::LEVEL_W-1:0] level_percent,
    input logic                              level_moved
);

    // one request in flight: ready drops right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while a request is in flight");

    // a stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pump_on) &&
        $stable(mode_now) && $stable(level_percent) && $stable(level_moved))
        else $error("stalled result changed");

    // every way into mode off stops the pump
    a_off_pump_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_now == tpl_pkg::MODE_OFF |-> !pump_on)
        else $error("pump running in mode off");

endmodule

bind tank_pump_level_controller tpl_checker u_tpl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (item.valid),
    .in_ready      (item.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .pump_on       (result.pump_on),
    .mode_now      (result.mode_now),
    .level_percent (result.level_percent),
    .level_moved   (result.level_moved)
);
